// ===== src/slt_pkg.sv =====
package slt_pkg;

  // field widths fixed by the item format
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RANK_W   = 9;

  // request codes (the unused code is handled as a search)
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

  // operation broadcast from the controller to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] value;
  } op_t;

  // compare flags a cell reports for the broadcast value
  typedef struct packed {
    logic lt;
    logic eq;
    logic first;
  } cmp_t;

endpackage

// ===== src/slt_cell.sv =====
module slt_cell
  import slt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  op_t                     op,
  input  logic                    left_lt,
  input  logic                    left_eq,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic                    left_vld,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic                    right_vld,
  output logic signed [VAL_W-1:0] val,
  output logic                    vld,
  output cmp_t                    cmp
);

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    vld_r, vld_nxt;

  // local compare against the broadcast value
  always_comb begin
    cmp.lt    = vld_r && (val_r < op.value);
    cmp.eq    = vld_r && (val_r == op.value);
    cmp.first = cmp.eq && !left_eq;
  end

  // insert shifts right from the insertion point, remove shifts left
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (op.ins && !cmp.lt) begin
      if (left_lt) begin
        val_nxt = op.value;
        vld_nxt = 1'b1;
      end else begin
        val_nxt = left_val;
        vld_nxt = left_vld;
      end
    end else if (op.rem && !cmp.lt) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

// ===== src/sorted_list_table.sv =====
// Sorted table of up to DEPTH signed 32-bit values, ascending, held in a row
// of cells. Each item inserts (before equal values), removes the first equal
// value, or searches for it; the result gives status, 1-based rank on a search
// hit and the count after the item. All cells compare against the broadcast
// value and shift by one place in the same cycle, and the result lands in an
// output register. A new item is taken in every cycle in which that register
// is empty or being drained, so the sustained rate is one item per clock. The
// table is empty after reset.
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int unsigned DEPTH = 16
)(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [RANK_W-1:0]       out_rank,
  output logic [RANK_W-1:0]       out_count
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]        cell_vld;
  cmp_t                    cell_cmp [DEPTH];
  logic [DEPTH-1:0]        first_vec;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;

  logic       in_fire;
  logic       full, empty, found;
  logic [IDX_W-1:0] first_idx;
  op_t        op;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign found    = |first_vec;

  // one-hot to index of the first equal cell
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  // operation broadcast to the cells
  always_comb begin
    op.value = in_value;
    op.ins   = in_fire && (in_req_type == REQ_INSERT) && !full;
    op.rem   = in_fire && (in_req_type == REQ_REMOVE) && found;
  end

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                    l_lt, l_eq, l_vld, r_vld;
    logic signed [VAL_W-1:0] l_val, r_val;

    if (g == 0) begin : g_first
      assign l_lt  = 1'b1;
      assign l_eq  = 1'b0;
      assign l_val = '0;
      assign l_vld = 1'b0;
    end else begin : g_mid
      assign l_lt  = cell_cmp[g-1].lt;
      assign l_eq  = cell_cmp[g-1].eq;
      assign l_val = cell_val[g-1];
      assign l_vld = cell_vld[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_val = cell_val[g+1];
      assign r_vld = cell_vld[g+1];
    end

    slt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .left_lt   (l_lt),
      .left_eq   (l_eq),
      .left_val  (l_val),
      .left_vld  (l_vld),
      .right_val (r_val),
      .right_vld (r_vld),
      .val       (cell_val[g]),
      .vld       (cell_vld[g]),
      .cmp       (cell_cmp[g])
    );

    assign first_vec[g] = cell_cmp[g].first;
  end

  // result and count for the current item
  always_comb begin
    count_nxt  = count_r;
    rank_nxt   = '0;
    status_nxt = ST_NOT_FOUND;
    case (in_req_type)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (found) begin
          status_nxt = ST_REMOVED;
          count_nxt  = count_r - 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        if (found) begin
          status_nxt = ST_FOUND;
          rank_nxt   = RANK_W'(first_idx) + 1'b1;
        end
      end
    endcase
  end

  // output register and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      status_r <= status_nxt;
      rank_r   <= rank_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_rank   = rank_r;
  assign out_count  = RANK_W'(count_r);

  // count stays in range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count above depth");

  // valid cells are exactly the held entries
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == int'(count_r))
    else $error("valid cells disagree with count");

  // at most one cell is the first equal match
  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_vec))
    else $error("several first matches");

  // accepted insert into a non-full table grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req_type == REQ_INSERT) && !full |=>
      count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow count");

  // a found search reports a nonzero rank
  a_found_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_FOUND) |-> rank_r != '0)
    else $error("found with zero rank");

endmodule

// ===== tb/sorted_list_table_test.sv =====
`timescale 1ns / 1ps
module sorted_list_table_test;
  import slt_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CALM_ITEMS = 100;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // the spare request code, which the block treats as a search
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  // random phase flavors
  localparam int unsigned PHASE_FILL = 0;
  localparam int unsigned PHASE_DRAIN = 1;

  typedef struct packed {
    logic [REQ_W-1:0]        req;
    logic signed [VAL_W-1:0] value;
  } table_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   rank;
    logic [RANK_W-1:0]   count;
  } table_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [REQ_W-1:0]        in_req_type = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [RANK_W-1:0]       out_rank;
  logic [RANK_W-1:0]       out_count;

  // stimulus, expectations and bookkeeping
  table_req_t              pending[$];
  table_result_t           results_due[$];
  logic signed [VAL_W-1:0] inserted_vals[$];
  int unsigned             total_items = 0;
  int unsigned             items_taken = 0;
  int unsigned             results_seen = 0;
  int unsigned             fail_count = 0;
  int unsigned             cycle_count = 0;
  int unsigned             send_gap = 0;
  int unsigned             send_gap_pct = 0;
  int unsigned             recv_stall = 0;
  int unsigned             recv_stall_pct = 0;
  logic                    calm;

  // shadow copy of the sorted table
  logic signed [VAL_W-1:0] sorted_vals[DEPTH];
  int unsigned             sorted_len = 0;

  assign calm = (items_taken + CALM_ITEMS >= total_items);

  sorted_list_table #(.DEPTH(DEPTH)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_rank    (out_rank),
    .out_count   (out_count)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // index of the first held value equal to v, or the length if absent
  function automatic int unsigned first_equal(logic signed [VAL_W-1:0] v);
    for (int unsigned k = 0; k < sorted_len; k++)
      if (sorted_vals[k] == v) return k;
    return sorted_len;
  endfunction

  // apply one item to the shadow table and return its result
  function automatic table_result_t apply_item(logic [REQ_W-1:0] req,
                                               logic signed [VAL_W-1:0] v);
    table_result_t r;
    int unsigned   pos;
    r = '0;
    case (req)
      REQ_INSERT: begin
        if (sorted_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new value goes ahead of any equal ones
          pos = 0;
          while (pos < sorted_len && sorted_vals[pos] < v) pos++;
          for (int unsigned k = sorted_len; k > pos; k--) sorted_vals[k] = sorted_vals[k-1];
          sorted_vals[pos] = v;
          sorted_len++;
          r.status = ST_INSERTED;
        end
      end
      REQ_REMOVE: begin
        if (sorted_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = first_equal(v);
          if (pos >= sorted_len) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int unsigned k = pos; k + 1 < sorted_len; k++) sorted_vals[k] = sorted_vals[k+1];
            sorted_len--;
            sorted_vals[sorted_len] = '0;
            r.status = ST_REMOVED;
          end
        end
      end
      default: begin
        // search, also for the spare code
        pos = first_equal(v);
        if (pos < sorted_len) begin
          r.status = ST_FOUND;
          r.rank = RANK_W'(pos + 1);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
    endcase
    r.count = RANK_W'(sorted_len);
    return r;
  endfunction

  // mostly a small cluster so that hits and duplicates are common
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return int'($urandom_range(0, 8)) - 4;
    if (sel < 75) begin
      case ($urandom_range(0, 6))
        0:       return 32'sh8000_0000;
        1:       return 32'sh8000_0001;
        2:       return -1;
        3:       return 0;
        4:       return 1;
        5:       return 32'sh7FFF_FFFE;
        default: return 32'sh7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // idle odds for a stretch of items, often none at all
  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic add_item(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] v);
    table_req_t t;
    t.req = req;
    t.value = v;
    pending.push_back(t);
    if (req == REQ_INSERT) begin
      inserted_vals.push_back(v);
      if (inserted_vals.size() > 2 * DEPTH) void'(inserted_vals.pop_front());
    end
  endtask

  task automatic build_stimulus();
    int unsigned             made;
    int unsigned             phase;
    int unsigned             run_len;
    int unsigned             roll;
    int unsigned             ins_pct;
    int unsigned             rem_pct;
    int unsigned             idx;
    logic signed [VAL_W-1:0] v;

    // empty table: search and remove
    add_item(REQ_SEARCH, 0);
    add_item(REQ_REMOVE, 0);
    // extremes and duplicates, duplicates go in ahead of equals
    add_item(REQ_INSERT, 32'sh7FFF_FFFF);
    add_item(REQ_INSERT, 32'sh8000_0000);
    add_item(REQ_INSERT, 0);
    add_item(REQ_INSERT, 0);
    add_item(REQ_INSERT, -1);
    add_item(REQ_SEARCH, 0);
    add_item(REQ_SPARE, 32'sh8000_0000);
    // absent value, then the first of two equals
    add_item(REQ_REMOVE, 12345);
    add_item(REQ_REMOVE, 0);
    // fill up, then one insert too many
    repeat (DEPTH - 4) add_item(REQ_INSERT, $urandom);
    add_item(REQ_INSERT, 0);

    // random phases that push toward full, toward empty, or stay mixed
    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase = $urandom_range(0, 2);
      run_len = $urandom_range(10, 40);
      case (phase)
        PHASE_FILL:  begin ins_pct = 75; rem_pct = 10; end
        PHASE_DRAIN: begin ins_pct = 10; rem_pct = 70; end
        default:     begin ins_pct = 35; rem_pct = 35; end
      endcase
      repeat (run_len) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
          add_item(REQ_INSERT, pick_value());
        end else if (roll < ins_pct + rem_pct) begin
          if (inserted_vals.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, inserted_vals.size() - 1);
            v = inserted_vals[idx];
            inserted_vals.delete(idx);
          end else begin
            v = pick_value();
          end
          add_item(REQ_REMOVE, v);
        end else begin
          if (inserted_vals.size() > 0 && $urandom_range(0, 2) != 0)
            v = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
          else
            v = pick_value();
          add_item(($urandom_range(0, 9) == 0) ? REQ_SPARE : REQ_SEARCH, v);
        end
        made++;
      end
    end
  endtask

  // driver: feeds pending items, predicts each one as it is accepted
  always @(posedge clk) begin
    table_req_t nxt;
    logic       busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        results_due.push_back(apply_item(in_req_type, in_value));
        items_taken++;
        if (items_taken % 64 == 0) send_gap_pct = pick_odds();
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() > 0) begin
          if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
            // this cycle is the first of the idle burst
            send_gap = $urandom_range(0, 12);
          end else begin
            nxt = pending.pop_front();
            in_req_type <= nxt.req;
            in_value <= nxt.value;
            busy = 1'b1;
          end
        end
      end
      in_valid <= busy;
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected item: status %0d rank %0d count %0d",
                 out_status, out_rank, out_count);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_rank !== want.rank) begin
            $error("rank: expected %0d, actual %0d", want.rank, out_rank);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_count);
            fail_count++;
          end
        end
        results_seen++;
        if (results_seen % 64 == 0) recv_stall_pct = pick_odds();
      end
      // back-pressure bursts
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < recv_stall_pct) begin
        recv_stall = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    build_stimulus();
    total_items = pending.size();
    send_gap_pct = pick_odds();
    recv_stall_pct = pick_odds();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every item to go in and every result to come back
    while (pending.size() > 0 || in_valid || results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sorted_list_table.f =====
src/slt_pkg.sv
src/slt_cell.sv
src/sorted_list_table.sv
tb/sorted_list_table_test.sv
